/* rtl/linear_probe_hash_table_unit_macros.svh */
// Assertion macros for the linear probe hash table unit
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define LPHT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LPHT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/lpht_pkg.sv */
// Shared types and codes of the linear probe hash table unit
`default_nettype none

package lpht_pkg;

    localparam int TABLE_DEPTH  = 4096;
    localparam int HASH_MODULUS = 3001;

    // key mod HASH_MODULUS by reciprocal multiply: 31 key bits plus 12 divisor bits
    localparam int          HASH_SHIFT = 43;
    localparam logic [31:0] HASH_RECIP =
        32'(((64'd1 << HASH_SHIFT) + 64'(HASH_MODULUS - 1)) / 64'(HASH_MODULUS));

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_FILLED  = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    localparam logic       REG_CAPACITY   = 1'b0;
    localparam logic [12:0] CAPACITY_RESET = 13'd4096;

    typedef struct packed {
        logic [1:0]  mark;
        logic [30:0] key;
        logic [7:0]  age;
    } t_slot_entry;

    typedef struct packed {
        logic clear;
        logic load;
        logic mod_step;
        logic probe_start;
        logic probe_step;
        logic commit;
        logic fail;
        logic fail_full;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_last;
        logic full_pre;
        logic mod_done;
        logic hit;
        logic miss;
        logic is_insert;
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/lpht_ctrl.sv */
// Sequencer of the linear probe hash table: clear sweep, hash, probe, result
`default_nettype none
`include "linear_probe_hash_table_unit_macros.svh"

module lpht_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [1:0]          i_command,
    input  lpht_pkg::t_dp_stat  i_stat,
    output logic                busy,
    output lpht_pkg::t_ctrl_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_PSTART = 3'd3;
    localparam logic [2:0] S_PROBE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       cmd_known;

    assign cmd_known = (i_command == lpht_pkg::CMD_INSERT) ||
                       (i_command == lpht_pkg::CMD_SEARCH) ||
                       (i_command == lpht_pkg::CMD_DELETE);

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    priority if (!cmd_known) begin
                        o_cmd.fail = 1'b1;
                    end else if (i_command == lpht_pkg::CMD_INSERT && i_stat.full_pre) begin
                        o_cmd.fail      = 1'b1;
                        o_cmd.fail_full = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_HASH;
                    end
                end
            end
            S_HASH: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_done) begin
                    n_state = S_PSTART;
                end
            end
            S_PSTART: begin
                o_cmd.probe_start = 1'b1;
                n_state           = S_PROBE;
            end
            S_PROBE: begin
                o_cmd.probe_step = 1'b1;
                priority if (i_stat.hit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_stat.miss) begin
                    o_cmd.fail      = 1'b1;
                    o_cmd.fail_full = i_stat.is_insert;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `LPHT_ASSERT_NEXT(a_clear_once, i_clk, i_rst_n, r_state != S_CLEAR, r_state != S_CLEAR, "clear sweep re-entered")
    `LPHT_ASSERT_NEXT(a_probe_ends, i_clk, i_rst_n, r_state == S_PROBE && (i_stat.hit || i_stat.miss), r_state == S_IDLE, "probe did not end on hit or miss")

endmodule

`default_nettype wire

/* rtl/lpht_dp.sv */
// Datapath: slot store, reciprocal hash remainder, probe pointer, count and result registers
`default_nettype none
`include "linear_probe_hash_table_unit_macros.svh"

module lpht_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpht_pkg::t_ctrl_cmd i_cmd,
    output lpht_pkg::t_dp_stat  o_stat,
    input  logic [1:0]          i_command,
    input  logic [30:0]         i_key_id,
    input  logic [7:0]          i_age,
    input  logic [12:0]         i_capacity,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [7:0]          o_found_age,
    output logic [11:0]         o_slot,
    output logic [12:0]         o_live_count
);

    localparam int IW = $clog2(lpht_pkg::TABLE_DEPTH);
    localparam int CW = $clog2(lpht_pkg::TABLE_DEPTH + 1);
    localparam int QW = 20;

    localparam logic [IW-1:0] POS_LAST = IW'(lpht_pkg::TABLE_DEPTH - 1);

    lpht_pkg::t_slot_entry r_mem [lpht_pkg::TABLE_DEPTH];
    lpht_pkg::t_slot_entry r_rd;
    lpht_pkg::t_slot_entry wr_data;

    logic [1:0]     r_cmd;
    logic [30:0]    r_key;
    logic [7:0]     r_age;
    logic [62:0]    r_prod;
    logic [IW-1:0]  r_rem;
    logic           r_mcnt;
    logic [IW-1:0]  r_pos;
    logic [CW-1:0]  r_n;
    logic [IW-1:0]  r_rd_pos;
    logic           r_rd_v;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           r_o_valid;
    logic [1:0]     r_status;
    logic [7:0]     r_found_age;
    logic [11:0]    r_slot;
    logic [12:0]    r_live;

    logic [62:0]    prod;
    logic [QW-1:0]  quot;
    logic [30:0]    quot_mul;
    logic [30:0]    rem_full;
    logic [31:0]    cap_clamp;
    logic [CW-1:0]  eff_cap;
    logic [IW-1:0]  home;
    logic [CW-1:0]  pos_inc;
    logic [IW-1:0]  pos_next;
    logic           issue;
    logic           is_ins;
    logic           is_del;
    logic           mem_we;
    logic [IW-1:0]  wr_addr;

    // effective capacity: clamp to [HASH_MODULUS, TABLE_DEPTH]
    always_comb begin
        cap_clamp = 32'(i_capacity);
        if (cap_clamp < 32'(lpht_pkg::HASH_MODULUS)) begin
            cap_clamp = 32'(lpht_pkg::HASH_MODULUS);
        end
        if (cap_clamp > 32'(lpht_pkg::TABLE_DEPTH)) begin
            cap_clamp = 32'(lpht_pkg::TABLE_DEPTH);
        end
    end
    assign eff_cap = CW'(cap_clamp);

    // step 0: quotient estimate by reciprocal; step 1: remainder by back-multiply
    assign prod     = 63'(r_key) * 63'(lpht_pkg::HASH_RECIP);
    assign quot     = r_prod[lpht_pkg::HASH_SHIFT +: QW];
    assign quot_mul = 31'(quot) * 31'(lpht_pkg::HASH_MODULUS);
    assign rem_full = r_key - quot_mul;

    // remainder is below HASH_MODULUS, which never exceeds the effective capacity
    assign home     = r_rem;

    assign pos_inc  = CW'(r_pos) + CW'(1);
    assign pos_next = (pos_inc == eff_cap) ? '0 : IW'(pos_inc);
    assign issue    = i_cmd.probe_step && (r_n < eff_cap);

    assign is_ins = (r_cmd == lpht_pkg::CMD_INSERT);
    assign is_del = (r_cmd == lpht_pkg::CMD_DELETE);

    assign o_stat.clear_last = (r_pos == POS_LAST);
    assign o_stat.full_pre   = (r_count >= eff_cap);
    assign o_stat.mod_done   = r_mcnt;
    assign o_stat.is_insert  = is_ins;
    assign o_stat.hit = r_rd_v && (is_ins ? (r_rd.mark != lpht_pkg::MARK_FILLED)
                                          : (r_rd.mark == lpht_pkg::MARK_FILLED &&
                                             r_rd.key == r_key));
    assign o_stat.miss = (r_rd_v && !is_ins && r_rd.mark == lpht_pkg::MARK_EMPTY) ||
                         (!r_rd_v && r_n == eff_cap);

    always_comb begin
        n_count = r_count;
        if (i_cmd.commit && is_ins) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.commit && is_del && r_count != '0) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        wr_addr = r_rd_pos;
        wr_data = '{mark: lpht_pkg::MARK_FILLED, key: r_key, age: r_age};
        mem_we  = i_cmd.commit && (is_ins || is_del);
        if (i_cmd.clear) begin
            wr_addr = r_pos;
            wr_data = '{mark: lpht_pkg::MARK_EMPTY, key: '0, age: '0};
            mem_we  = 1'b1;
        end else if (is_del) begin
            wr_data = '{mark: lpht_pkg::MARK_DELETED, key: r_rd.key, age: r_rd.age};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd     <= r_mem[r_pos];
        r_rd_pos <= r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_n       <= '0;
            r_rd_v    <= 1'b0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_mcnt    <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.commit || i_cmd.fail;
            r_count   <= n_count;
            if (i_cmd.load) begin
                r_mcnt <= 1'b0;
            end else if (i_cmd.mod_step) begin
                r_mcnt <= ~r_mcnt;
            end
            priority if (i_cmd.clear) begin
                r_pos <= r_pos + IW'(1);
            end else if (i_cmd.probe_start) begin
                r_pos  <= home;
                r_n    <= '0;
                r_rd_v <= 1'b0;
            end else if (i_cmd.probe_step) begin
                r_rd_v <= issue;
                if (issue) begin
                    r_pos <= pos_next;
                    r_n   <= r_n + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_key <= i_key_id;
            r_age <= i_age;
        end else if (i_cmd.mod_step) begin
            if (r_mcnt) begin
                r_rem <= rem_full[IW-1:0];
            end else begin
                r_prod <= prod;
            end
        end
        if (i_cmd.commit) begin
            r_status    <= lpht_pkg::STATUS_OK;
            r_found_age <= is_ins ? 8'd0 : r_rd.age;
            r_slot      <= 12'(r_rd_pos);
            r_live      <= 13'(n_count);
        end else if (i_cmd.fail) begin
            r_status    <= i_cmd.fail_full ? lpht_pkg::STATUS_FULL : lpht_pkg::STATUS_NOT_FOUND;
            r_found_age <= 8'd0;
            r_slot      <= 12'd0;
            r_live      <= 13'(r_count);
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_status;
    assign o_found_age  = r_found_age;
    assign o_slot       = r_slot;
    assign o_live_count = r_live;

    `LPHT_ASSERT_IMPL(a_probe_bound, i_clk, i_rst_n, i_cmd.probe_step, r_n <= eff_cap, "probe count beyond capacity")
    `LPHT_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, i_cmd.commit && is_ins, r_count == $past(r_count) + CW'(1), "insert did not raise count")

endmodule

`default_nettype wire

/* rtl/linear_probe_hash_table_unit.sv */
// Top level of the linear probe hash table unit: config register, sequencer, datapath
//
//  channel   handshake                       payload
//  request   start, busy (take: start&!busy) i_command, i_key_id, i_age
//  result    o_valid (one cycle, no stall)   o_status, o_found_age, o_slot, o_live_count
//  config    psel/penable/pwrite, pready=1   paddr, pwdata, prdata (capacity at 0x0)
//
// A hashed request raises o_valid after the reciprocal remainder (quotient estimate, then
// back-multiply), one probe setup state and the slot reads, one per cycle through the
// store's registered read port. An insert that finds no free slot answers after its last
// read. Inserts into a full table and unknown commands answer in the next cycle. After
// reset busy stays high for a clearing pass over all TABLE_DEPTH slot marks; config
// writes are taken. Results never stall.
`default_nettype none

module linear_probe_hash_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [30:0] i_key_id,
    input  logic [7:0]  i_age,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [7:0]  o_found_age,
    output logic [11:0] o_slot,
    output logic [12:0] o_live_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [12:0]         r_capacity;
    lpht_pkg::t_ctrl_cmd cmd;
    lpht_pkg::t_dp_stat  stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lpht_pkg::REG_CAPACITY) ? 32'(r_capacity) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lpht_pkg::CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == lpht_pkg::REG_CAPACITY) begin
            r_capacity <= pwdata[12:0];
        end
    end

    lpht_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_stat    (stat),
        .busy      (busy),
        .o_cmd     (cmd)
    );

    lpht_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_command    (i_command),
        .i_key_id     (i_key_id),
        .i_age        (i_age),
        .i_capacity   (r_capacity),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_found_age  (o_found_age),
        .o_slot       (o_slot),
        .o_live_count (o_live_count)
    );

endmodule

`default_nettype wire

/* test/linear_probe_hash_table_unit_tb.sv */
// Self-checking testbench for the linear probe hash table unit with its own table predictor
`timescale 1ns / 100ps

module linear_probe_hash_table_unit_tb;

    localparam int TABLE_DEPTH  = lpht_pkg::TABLE_DEPTH;
    localparam int HASH_MODULUS = lpht_pkg::HASH_MODULUS;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [30:0] key;
        logic [7:0]  age;
    } t_request;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  found_age;
        logic [11:0] slot;
        logic [12:0] live_count;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [30:0] i_key_id;
    logic [7:0]  i_age;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_found_age;
    logic [11:0] o_slot;
    logic [12:0] o_live_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    linear_probe_hash_table_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_key_id    (i_key_id),
        .i_age       (i_age),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_found_age (o_found_age),
        .o_slot      (o_slot),
        .o_live_count(o_live_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // shadow copy of the table
    logic [1:0]  shadow_mark [TABLE_DEPTH];
    logic [30:0] shadow_key  [TABLE_DEPTH];
    logic [7:0]  shadow_age  [TABLE_DEPTH];
    int          shadow_count;
    logic [12:0] shadow_cap_reg;

    t_request    request_queue[$];
    t_outcome    awaited_outcomes[$];
    logic [30:0] key_pool[$];

    int idle_left;
    bit no_idle;
    int mismatches;
    int requests_sent;
    int results_checked;
    int full_answers;
    int hits;
    int capacity_writes;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("Timeout: requests still outstanding");
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int home_slot(input logic [30:0] key, input int cap);
        int h;
        h = int'(key % HASH_MODULUS);
        if (h >= cap) h = h % cap;
        return h;
    endfunction

    function automatic t_outcome table_op(input logic [1:0] cmd, input logic [30:0] key,
                                          input logic [7:0] age);
        t_outcome res;
        int cap;
        int pos;
        int n;
        bit done;
        cap = shadow_cap_reg;
        if (cap < HASH_MODULUS) cap = HASH_MODULUS;
        if (cap > TABLE_DEPTH) cap = TABLE_DEPTH;
        res.status = lpht_pkg::STATUS_NOT_FOUND;
        res.found_age = '0;
        res.slot = '0;
        done = 1'b0;
        if (cmd == lpht_pkg::CMD_INSERT) begin
            res.status = lpht_pkg::STATUS_FULL;
            if (shadow_count < cap) begin
                pos = home_slot(key, cap);
                for (n = 0; n < cap && !done; n++) begin
                    if (shadow_mark[pos] != lpht_pkg::MARK_FILLED) begin
                        shadow_mark[pos] = lpht_pkg::MARK_FILLED;
                        shadow_key[pos] = key;
                        shadow_age[pos] = age;
                        shadow_count++;
                        res.status = lpht_pkg::STATUS_OK;
                        res.slot = 12'(pos);
                        done = 1'b1;
                    end else begin
                        pos = (pos + 1 >= cap) ? 0 : pos + 1;
                    end
                end
            end
            if (res.status == lpht_pkg::STATUS_FULL) full_answers++;
        end else if (cmd == lpht_pkg::CMD_SEARCH || cmd == lpht_pkg::CMD_DELETE) begin
            pos = home_slot(key, cap);
            for (n = 0; n < cap && !done; n++) begin
                if (shadow_mark[pos] == lpht_pkg::MARK_EMPTY) begin
                    done = 1'b1;
                end else if (shadow_mark[pos] == lpht_pkg::MARK_FILLED &&
                             shadow_key[pos] == key) begin
                    res.status = lpht_pkg::STATUS_OK;
                    res.found_age = shadow_age[pos];
                    res.slot = 12'(pos);
                    hits++;
                    if (cmd == lpht_pkg::CMD_DELETE) begin
                        shadow_mark[pos] = lpht_pkg::MARK_DELETED;
                        if (shadow_count > 0) shadow_count--;
                    end
                    done = 1'b1;
                end else begin
                    pos = (pos + 1 >= cap) ? 0 : pos + 1;
                end
            end
        end
        res.live_count = 13'(shadow_count);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : drive_requests
        t_request nxt;
        int roll;
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy) begin
                awaited_outcomes.push_back(table_op(i_command, i_key_id, i_age));
                requests_sent++;
            end
            if (!start || !busy) begin
                if (idle_left > 0) begin
                    start <= 1'b0;
                    if (!busy) idle_left <= idle_left - 1;
                end else if (request_queue.size() > 0) begin
                    nxt = request_queue.pop_front();
                    i_command <= nxt.cmd;
                    i_key_id <= nxt.key;
                    i_age <= nxt.age;
                    start <= 1'b1;
                    roll = $urandom_range(0, 99);
                    if (no_idle || roll < 50) idle_left <= 0;
                    else if (roll < 90) idle_left <= $urandom_range(1, 3);
                    else idle_left <= $urandom_range(8, 40);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (awaited_outcomes.size() == 0) begin
                report_mismatch("result with no request pending", 1, 0);
            end else begin
                want = awaited_outcomes.pop_front();
                results_checked++;
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_found_age !== want.found_age)
                    report_mismatch("found_age", o_found_age, want.found_age);
                if (o_slot !== want.slot)
                    report_mismatch("slot", o_slot, want.slot);
                if (o_live_count !== want.live_count)
                    report_mismatch("live_count", o_live_count, want.live_count);
            end
        end
    end

    task automatic queue_request(input logic [1:0] cmd, input logic [30:0] key,
                                 input logic [7:0] age);
        t_request req;
        req.cmd = cmd;
        req.key = key;
        req.age = age;
        request_queue.push_back(req);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (request_queue.size() != 0 || start || awaited_outcomes.size() != 0 || busy);
    endtask

    task automatic write_capacity(input logic [12:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {lpht_pkg::REG_CAPACITY, 2'b00};
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_cap_reg = value;
        capacity_writes++;
    endtask

    task automatic check_capacity_readback();
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {lpht_pkg::REG_CAPACITY, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== 32'(shadow_cap_reg))
            report_mismatch("capacity readback", prdata, shadow_cap_reg);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [30:0] same_home_key(input int home);
        return 31'(home + HASH_MODULUS * $urandom_range(0, 700000));
    endfunction

    task automatic random_phase(input int count, input bit burst);
        int roll;
        logic [30:0] key;
        no_idle = burst;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            key = 31'($urandom);
            if (key_pool.size() > 0 && roll >= 40 && roll < 85)
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if (roll < 40 || key_pool.size() == 0) begin
                queue_request(lpht_pkg::CMD_INSERT, key, 8'($urandom));
                key_pool.push_back(key);
            end else if (roll < 50) begin
                // collide with a known key's home slot
                key = same_home_key(int'(key % HASH_MODULUS));
                queue_request(lpht_pkg::CMD_INSERT, key, 8'($urandom));
                key_pool.push_back(key);
            end else if (roll < 70) begin
                queue_request(lpht_pkg::CMD_SEARCH, key, 8'($urandom));
            end else if (roll < 85) begin
                queue_request(lpht_pkg::CMD_DELETE, key, 8'($urandom));
            end else if (roll < 95) begin
                queue_request(roll[0] ? lpht_pkg::CMD_SEARCH : lpht_pkg::CMD_DELETE, key,
                              8'($urandom));
            end else begin
                queue_request(CMD_UNUSED, key, 8'($urandom));
            end
        end
        wait_idle();
    endtask

    initial begin
        foreach (shadow_mark[i]) begin
            shadow_mark[i] = lpht_pkg::MARK_EMPTY;
            shadow_key[i] = '0;
            shadow_age[i] = '0;
        end
        shadow_count = 0;
        shadow_cap_reg = lpht_pkg::CAPACITY_RESET;
        no_idle = 1'b0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_command <= lpht_pkg::CMD_INSERT;
        i_key_id <= '0;
        i_age <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_capacity_readback();

        // collisions, duplicates, reuse of deleted slots, unused command
        queue_request(lpht_pkg::CMD_INSERT, 31'd0, 8'd0);
        queue_request(lpht_pkg::CMD_INSERT, 31'h7FFF_FFFF, 8'd255);
        queue_request(lpht_pkg::CMD_SEARCH, 31'h7FFF_FFFF, 8'd0);
        queue_request(lpht_pkg::CMD_INSERT, 31'd3001, 8'h5A);
        queue_request(lpht_pkg::CMD_INSERT, 31'd3001, 8'hA5);
        queue_request(lpht_pkg::CMD_SEARCH, 31'd3001, 8'd0);
        queue_request(lpht_pkg::CMD_DELETE, 31'd0, 8'd0);
        queue_request(lpht_pkg::CMD_SEARCH, 31'd3001, 8'd0);
        queue_request(lpht_pkg::CMD_SEARCH, 31'd0, 8'd0);
        queue_request(lpht_pkg::CMD_INSERT, 31'd6002, 8'd1);
        queue_request(lpht_pkg::CMD_DELETE, 31'd0, 8'd0);
        queue_request(CMD_UNUSED, 31'h7FFF_FFFF, 8'd255);
        queue_request(lpht_pkg::CMD_INSERT, 31'd3000, 8'd10);
        queue_request(lpht_pkg::CMD_INSERT, 31'd6001, 8'd11);
        queue_request(lpht_pkg::CMD_INSERT, 31'd9002, 8'd12);
        queue_request(lpht_pkg::CMD_INSERT, 31'd12003, 8'd13);
        queue_request(lpht_pkg::CMD_SEARCH, 31'd12003, 8'd0);
        wait_idle();

        // lowered capacity: entries past the end are stranded, probes wrap
        write_capacity(13'd3001);
        check_capacity_readback();
        queue_request(lpht_pkg::CMD_SEARCH, 31'd12003, 8'd0);
        queue_request(lpht_pkg::CMD_INSERT, 31'd15004, 8'd14);
        queue_request(lpht_pkg::CMD_DELETE, 31'd3000, 8'd0);
        queue_request(lpht_pkg::CMD_SEARCH, 31'd6001, 8'd0);
        queue_request(lpht_pkg::CMD_INSERT, 31'd0, 8'd255);
        wait_idle();

        write_capacity(13'd0);
        random_phase(140, 1'b0);
        write_capacity(13'h1FFF);
        random_phase(140, 1'b1);
        write_capacity(13'd3500);
        check_capacity_readback();
        random_phase(130, 1'b0);
        write_capacity(13'd4096);
        random_phase(120, 1'b0);

        // reuse of a freed slot and a short collision chain
        write_capacity(13'd3001);
        queue_request(lpht_pkg::CMD_DELETE, key_pool[key_pool.size() - 1], 8'd0);
        queue_request(lpht_pkg::CMD_INSERT, same_home_key(5), 8'd200);
        queue_request(lpht_pkg::CMD_INSERT, same_home_key(5), 8'd201);
        queue_request(CMD_UNUSED, 31'd0, 8'd0);
        wait_idle();

        repeat (40) @(posedge i_clk);
        $display("Checked %0d results from %0d requests over %0d capacity settings",
                 results_checked, requests_sent, capacity_writes);
        $display("Key hits: %0d, table-full answers: %0d, final live count: %0d",
                 hits, full_answers, shadow_count);
        if (mismatches == 0 && awaited_outcomes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
